// ===== rtl/sorted_insert_ranking_list_top_macros.svh =====
// assertion macros shared by the ranking list rtl
`ifndef SORTED_INSERT_RANKING_LIST_TOP_MACROS_SVH
`define SORTED_INSERT_RANKING_LIST_TOP_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SIRL_ASSERT_HOLDS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next cycle
`define SIRL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sirl_pkg.sv =====
// shared types, constants and helpers for the ranking list
`timescale 1ns / 1ps
package sirl_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int SCORE_W    = 16;
	localparam int TAG_W      = 16;
	localparam int RANK_W     = 4;
	localparam int IDX_W      = $clog2(LIST_DEPTH);
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

	typedef enum logic [0:0] {
		OP_INSERT  = 1'b0,
		OP_READOUT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_INSERTED = 2'd0,
		STATUS_DROPPED  = 2'd1,
		STATUS_EMPTY    = 2'd2,
		STATUS_LISTED   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_ROTATE = 2'd2
	} cell_cmd_t;

	typedef enum logic [0:0] {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} seq_state_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [TAG_W-1:0]          tag;
	} entry_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_cmd_t                 cmd;
		logic signed [SCORE_W-1:0] key;
		logic [TAG_W-1:0]          tag;
	} cell_ctrl_t;

	// low rank bits of a list position, zero extended for shallow lists
	function automatic logic [RANK_W-1:0] rank_of(input logic [IDX_W-1:0] idx);
		logic [IDX_W+RANK_W-1:0] wide;
		wide = {{RANK_W{1'b0}}, idx};
		return wide[RANK_W-1:0];
	endfunction

endpackage

// ===== rtl/sirl_cell.sv =====
// one list slot: holds an entry, compares it and shifts on insert or readout
`timescale 1ns / 1ps
module sirl_cell (
	input  logic                clk,
	input  sirl_pkg::cell_ctrl_t ctrl,
	input  sirl_pkg::entry_t    left_entry,
	input  logic                left_cmp,
	input  sirl_pkg::entry_t    right_entry,
	input  logic                occupied,
	output sirl_pkg::entry_t    entry,
	output logic                cmp
);
	import sirl_pkg::*;

	entry_t entry_q;

	// new entry belongs here or further up when this slot is free or not higher
	assign cmp   = !occupied || (entry_q.score <= ctrl.key);
	assign entry = entry_q;

	// slot update: take left neighbour on insert shift, right neighbour on rotate
	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			CELL_INSERT: begin
				if (left_cmp) begin
					entry_q <= left_entry;
				end else if (cmp) begin
					entry_q <= '{score: ctrl.key, tag: ctrl.tag};
				end
			end
			CELL_ROTATE: begin
				entry_q <= right_entry;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule

// ===== rtl/sirl_chain.sv =====
// row of list cells, head at cell zero
`timescale 1ns / 1ps
module sirl_chain (
	input  logic                       clk,
	input  sirl_pkg::cell_ctrl_t       ctrl,
	input  logic [sirl_pkg::CNT_W-1:0] count,
	output sirl_pkg::entry_t           head
);
	import sirl_pkg::*;

	entry_t entries [LIST_DEPTH];
	logic   cmps    [LIST_DEPTH];

	// cells wired to both neighbours, the ring closes for readout rotation
	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		entry_t left_entry;
		logic   left_cmp;
		logic   occupied;

		if (i == 0) begin : g_head
			assign left_entry = '{score: ctrl.key, tag: ctrl.tag};
			assign left_cmp   = 1'b0;
		end else begin : g_body
			assign left_entry = entries[i-1];
			assign left_cmp   = cmps[i-1];
		end

		assign occupied = (count > CNT_W'(i));

		sirl_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.left_entry (left_entry),
			.left_cmp   (left_cmp),
			.right_entry(entries[(i + 1) % LIST_DEPTH]),
			.occupied   (occupied),
			.entry      (entries[i]),
			.cmp        (cmps[i])
		);
	end

	assign head = entries[0];

endmodule

// ===== rtl/sorted_insert_ranking_list_top.sv =====
// ranking list top: sequencer, entry count and registered result port
// insert: result valid the cycle after acceptance; one insert per cycle without output stall
// readout of a non-empty list: results come via read state; one per cycle unless stalled
// input stays closed while the read state rotates the ring round, longer under output stall
// reset clears the entry count and the result valid flag; slot contents stay undefined
`timescale 1ns / 1ps
module sorted_insert_ranking_list_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // score [15:0], student_tag [31:16]
	input  logic [0:0]  s_tuser,  // op [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // out_score [15:0], out_tag [31:16], rank [35:32], zero pad
	output logic [1:0]  m_tuser,  // status [1:0]
	output logic        m_tlast
);
	import sirl_pkg::*;
	`include "sorted_insert_ranking_list_top_macros.svh"

	seq_state_t       state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;

	logic                      out_valid_q;
	status_t                   out_status_q;
	logic signed [SCORE_W-1:0] out_score_q;
	logic [TAG_W-1:0]          out_tag_q;
	logic [RANK_W-1:0]         out_rank_q;
	logic                      out_last_q;

	cell_ctrl_t ctrl;
	entry_t     head;
	logic       out_free;
	logic       in_accept;
	logic       is_full;
	logic       is_empty;
	logic       emit_need;
	logic       step;
	logic       last_step;

	logic                      out_load;
	status_t                   out_status;
	logic signed [SCORE_W-1:0] out_score;
	logic [TAG_W-1:0]          out_tag;
	logic [RANK_W-1:0]         out_rank;
	logic                      out_last;

	// handshake and status terms
	assign out_free  = !out_valid_q || m_tready;
	assign in_accept = s_tvalid && s_tready;
	assign is_full   = (count_q == CNT_W'(LIST_DEPTH));
	assign is_empty  = (count_q == '0);
	assign emit_need = (CNT_W'(idx_q) < count_q);
	assign step      = (state_q == ST_READ) && (!emit_need || out_free);
	assign last_step = (idx_q == IDX_W'(LIST_DEPTH - 1));

	// cell chain
	sirl_chain u_chain (
		.clk  (clk),
		.ctrl (ctrl),
		.count(count_q),
		.head (head)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && (op_t'(s_tuser[0]) == OP_READOUT) && !is_empty) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (step && last_step) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// sequencer outputs: input ready, cell command and result load
	always_comb begin
		s_tready   = 1'b0;
		ctrl       = '{cmd: CELL_HOLD, key: s_tdata[15:0], tag: s_tdata[31:16]};
		out_load   = 1'b0;
		out_status = STATUS_INSERTED;
		out_score  = '0;
		out_tag    = '0;
		out_rank   = '0;
		out_last   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = out_free;
				if (in_accept) begin
					out_load = 1'b1;
					if (op_t'(s_tuser[0]) == OP_INSERT) begin
						ctrl.cmd   = CELL_INSERT;
						out_status = is_full ? STATUS_DROPPED : STATUS_INSERTED;
					end else if (is_empty) begin
						out_status = STATUS_EMPTY;
					end else begin
						out_load = 1'b0;
					end
				end
			end
			ST_READ: begin
				if (step) begin
					ctrl.cmd = CELL_ROTATE;
				end
				if (step && emit_need) begin
					out_load   = 1'b1;
					out_status = STATUS_LISTED;
					out_score  = head.score;
					out_tag    = head.tag;
					out_rank   = rank_of(idx_q);
					out_last   = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
				end
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept && (op_t'(s_tuser[0]) == OP_INSERT) && !is_full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (step) begin
				idx_q <= last_step ? '0 : idx_q + IDX_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= out_status;
			out_score_q  <= out_score;
			out_tag_q    <= out_tag;
			out_rank_q   <= out_rank;
			out_last_q   <= out_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_rank_q, out_tag_q, out_score_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	`SIRL_ASSERT_HOLDS(a_count_bound, count_q <= CNT_W'(LIST_DEPTH), "entry count beyond depth")
	`SIRL_ASSERT_NEXT(a_insert_grows, in_accept && !s_tuser[0] && !is_full, count_q == $past(count_q) + CNT_W'(1), "insert did not grow the list")
	`SIRL_ASSERT_HOLDS(a_read_count_stable, (state_q == ST_READ) |-> $stable(count_q), "entry count moved during readout")
	`SIRL_ASSERT_HOLDS(a_read_start_idx, $rose(state_q == ST_READ) |-> (idx_q == '0), "readout began away from the head")

endmodule

// ===== tb/sv/ranking_list_checker.sv =====
// checker for the ranking list: predicts every result from the input channel and compares
`timescale 1ns / 1ps
module ranking_list_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,  // score [15:0], student_tag [31:16]
	input  logic [0:0]  s_tuser,  // op [0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,  // out_score [15:0], out_tag [31:16], rank [35:32], zero pad
	input  logic [1:0]  m_tuser,  // status [1:0]
	input  logic        m_tlast,
	output int          mismatch_count,
	output int          open_results
);
	import sirl_pkg::*;

	typedef struct {
		status_t                   status;
		logic signed [SCORE_W-1:0] score;
		logic [TAG_W-1:0]          tag;
		logic [RANK_W-1:0]         rank;
		logic                      last;
	} ranking_result_t;

	// results still owed by the block, oldest first
	ranking_result_t ranking_results_q[$];

	// shadow copy of the ranking
	logic signed [SCORE_W-1:0] shadow_score [LIST_DEPTH];
	logic [TAG_W-1:0]          shadow_tag   [LIST_DEPTH];
	int                        shadow_count;

	initial begin
		mismatch_count = 0;
		open_results   = 0;
		shadow_count   = 0;
	end

	task automatic queue_result(input status_t st, input logic signed [SCORE_W-1:0] sc,
			input logic [TAG_W-1:0] tg, input logic [RANK_W-1:0] rk, input logic lst);
		ranking_result_t r;
		r.status = st;
		r.score  = sc;
		r.tag    = tg;
		r.rank   = rk;
		r.last   = lst;
		ranking_results_q.push_back(r);
	endtask

	// sorted insertion: new entry goes ahead of every lower or equal score
	task automatic insert_entry(input logic signed [SCORE_W-1:0] key,
			input logic [TAG_W-1:0] tg);
		int pos;
		int top_slot;
		bit full;
		bit found;
		pos   = shadow_count;
		full  = (shadow_count == LIST_DEPTH);
		found = 1'b0;
		for (int i = 0; i < shadow_count; i++) begin
			if (!found && shadow_score[i] <= key) begin
				pos   = i;
				found = 1'b1;
			end
		end
		// on a full list the bottom entry is overwritten by the shift
		top_slot = full ? LIST_DEPTH - 1 : shadow_count;
		if (pos < LIST_DEPTH) begin
			for (int i = top_slot; i > pos; i--) begin
				shadow_score[i] = shadow_score[i-1];
				shadow_tag[i]   = shadow_tag[i-1];
			end
			shadow_score[pos] = key;
			shadow_tag[pos]   = tg;
		end
		if (!full)
			shadow_count++;
		queue_result(full ? STATUS_DROPPED : STATUS_INSERTED, '0, '0, '0, 1'b1);
	endtask

	// readout in rank order, or a single empty status
	task automatic list_ranking();
		if (shadow_count == 0) begin
			queue_result(STATUS_EMPTY, '0, '0, '0, 1'b1);
		end else begin
			for (int i = 0; i < shadow_count; i++)
				queue_result(STATUS_LISTED, shadow_score[i], shadow_tag[i], RANK_W'(i),
					(i == shadow_count - 1));
		end
	endtask

	task automatic check_result();
		ranking_result_t exp_r;
		if (ranking_results_q.size() == 0) begin
			$error("result with nothing predicted: status %0d score %0d tag %0d",
				m_tuser, $signed(m_tdata[15:0]), m_tdata[31:16]);
			mismatch_count++;
		end else begin
			exp_r = ranking_results_q.pop_front();
			if (m_tuser !== exp_r.status) begin
				$error("status: expected %0d, got %0d", exp_r.status, m_tuser);
				mismatch_count++;
			end
			if (m_tdata[15:0] !== exp_r.score) begin
				$error("out_score: expected %0d, got %0d", exp_r.score, $signed(m_tdata[15:0]));
				mismatch_count++;
			end
			if (m_tdata[31:16] !== exp_r.tag) begin
				$error("out_tag: expected %0d, got %0d", exp_r.tag, m_tdata[31:16]);
				mismatch_count++;
			end
			if (m_tdata[35:32] !== exp_r.rank) begin
				$error("rank: expected %0d, got %0d", exp_r.rank, m_tdata[35:32]);
				mismatch_count++;
			end
			if (m_tlast !== exp_r.last) begin
				$error("last: expected %0d, got %0d", exp_r.last, m_tlast);
				mismatch_count++;
			end
		end
	endtask

	// watch both channels; predictions are pushed before the compare of the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (op_t'(s_tuser) == OP_INSERT)
					insert_entry(s_tdata[15:0], s_tdata[31:16]);
				else
					list_ranking();
			end
			if (m_tvalid && m_tready)
				check_result();
		end
		open_results = ranking_results_q.size();
	end

endmodule

// ===== tb/sv/sorted_insert_ranking_list_top_test.sv =====
// testbench top for the ranking list: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 1ps
module sorted_insert_ranking_list_top_test;
	import sirl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // score [15:0], student_tag [31:16]
	logic [0:0]  s_tuser;  // op [0]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;  // out_score [15:0], out_tag [31:16], rank [35:32], zero pad
	logic [1:0]  m_tuser;  // status [1:0]
	logic        m_tlast;

	int mismatch_count;
	int open_results;
	int tx_idle_pct;
	int rx_idle_pct;
	bit rx_hold_req;
	int cycle_count;

	sorted_insert_ranking_list_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	ranking_list_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.mismatch_count (mismatch_count),
		.open_results   (open_results)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: random back-pressure, or a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end else begin
				m_tready <= (int'($urandom_range(99)) >= rx_idle_pct);
			end
		end
	end

	// offer one transaction, with random idle cycles ahead of it
	task automatic send_item(input op_t op, input int score_val, input logic [TAG_W-1:0] tg);
		while (int'($urandom_range(99)) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {tg, SCORE_W'(score_val)};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// stop offering and wait for every predicted result
	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (open_results != 0) @(posedge clk);
	endtask

	// scores lean towards the extremes and a narrow band that produces ties
	function automatic int random_score();
		case ($urandom_range(9))
			0:       return 32767;
			1:       return -32768;
			2, 3, 4: return int'($urandom_range(15)) - 8;
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	task automatic run_random(input int tx_pct, input int rx_pct, input int n_items,
			input bit hold_off);
		op_t op;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		if (hold_off)
			rx_hold_req = 1'b1;
		for (int k = 0; k < n_items; k++) begin
			op = ($urandom_range(99) < 15) ? OP_READOUT : OP_INSERT;
			send_item(op, random_score(), TAG_W'($urandom));
		end
		wait_all_results();
	endtask

	// stimulus and verdict
	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = OP_INSERT;
		tx_idle_pct = 34;
		rx_idle_pct = 67;
		rx_hold_req = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty readout, ties, extremes, filling and dropping
		send_item(OP_READOUT, 32767, 16'hffff);
		send_item(OP_INSERT, 0, 16'h0001);
		send_item(OP_INSERT, 0, 16'h0002);
		send_item(OP_INSERT, 32767, 16'h0000);
		send_item(OP_INSERT, -1, 16'hffff);
		send_item(OP_READOUT, -32768, 16'h0000);
		for (int k = 0; k < 12; k++)
			send_item(OP_INSERT, k * 1000 - 5000, TAG_W'(16'h0100 + k));
		// full list: new entry below every stored one drops itself
		send_item(OP_INSERT, -32768, 16'haaaa);
		// full list: ties at bottom and top push the lowest entry off
		send_item(OP_INSERT, -5000, 16'h5555);
		send_item(OP_INSERT, 32767, 16'h8001);
		send_item(OP_READOUT, 0, 16'h0000);
		wait_all_results();

		// random phases: sender busy, receiver busy, then no random idling but a hold-off
		run_random(34, 67, 120, 1'b0);
		run_random(67, 34, 120, 1'b0);
		run_random(0, 0, 120, 1'b1);

		repeat (LIST_DEPTH + 4) @(posedge clk);
		if (mismatch_count == 0 && open_results == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
